@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define KPI_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe interpolator assertion failed");

// Implication checked in the cycle after the antecedent
`define KPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe interpolator assertion failed");

`endif

@@ design/kpi_pkg.sv @@
// Types and constants of the keyframe position interpolator
`default_nettype none
package kpi_pkg;

  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0] stamp;
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] y;
    logic [KEY_W-1:0] z;
  } key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDA,
    ST_GETA,
    ST_DEC,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } st_t;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // register index taken from the word address bit
  localparam logic REG_KEYS_IN_USE = 1'b0;

endpackage
`default_nettype wire

@@ design/keyframe_position_interpolator_top.sv @@
// Keyframe position interpolator: key table memory, segment scan, blend datapath
//
// Keys live in one synchronous memory (time and x/y/z per entry). A write item
// stores its key in the cycle it is accepted and produces no result. A sample
// item scans key times one read per cycle from key 1 upward, reads the segment
// start key, runs a one-bit-per-cycle divider for the blend factor (skipped
// when the factor is clamped), then blends x, y and z through one shared
// multiplier, a multiply step and an add step per axis. The input is stalled
// while a sample is processed. The result sits in an output register until
// taken, and the next item is accepted while it waits. The key table has no
// reset.
`default_nettype none
module keyframe_position_interpolator_top
  import kpi_pkg::*;
#(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      req_type,
  input  wire logic [5:0]                key_slot,
  input  wire logic [31:0]               key_stamp,
  input  wire logic signed [31:0]        key_vx,
  input  wire logic signed [31:0]        key_vy,
  input  wire logic signed [31:0]        key_vz,
  input  wire logic [31:0]               sample_time,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             out_vx,
  output logic signed [31:0]             out_vy,
  output logic signed [31:0]             out_vz,
  output logic [5:0]                     segment_start,
  output logic [FRAC_BITS:0]             blend_amount,
  output logic                           held_start
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = AW + 1;
  localparam int FW = FRAC_BITS + 1;
  localparam int PW = KEY_W + 1 + FW + 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // configuration
  logic [6:0] keys_in_use;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KEYS_IN_USE);
  assign prdata = (paddr[2] == REG_KEYS_IN_USE) ? 32'(keys_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) keys_in_use <= 7'd1;
    else if (cfg_wr) keys_in_use <= pwdata[6:0];
  end

  // key memory
  key_t          mem [MAX_KEYS];
  key_t          rdata;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic          rd_en;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= '{stamp: key_stamp, x: key_vx, y: key_vy, z: key_vz};
    if (rd_en) rdata <= mem[raddr];
  end

  // control
  st_t           state, state_next;
  logic          in_acc;
  logic [NW-1:0] n;
  logic [NW-1:0] n_acc;
  logic [NW-1:0] cnt;
  logic [AW-1:0] ra;
  logic          rv;
  logic          hit;
  logic          single;
  logic [31:0]   t;
  logic [AW-1:0] seg;
  key_t          key_a, key_b;
  logic [FW-1:0] factor;
  logic          held;
  logic [1:0]    ax;
  logic          issue;
  logic          div_start;
  logic          div_done;
  logic [FRAC_BITS-1:0] div_quo;
  logic          load_out;
  logic          use_div;
  logic [FW-1:0] dec_factor;
  logic [31:0]   num, den;
  logic          dec_held;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    int unsigned kv;
    kv = 32'(keys_in_use);
    if (kv == 0) kv = 1;
    if (kv > MAX_KEYS) kv = MAX_KEYS;
    n_acc = NW'(kv);
  end

  assign hit = rv && ((t < rdata.stamp) || (NW'(ra) == n - 1'b1));

  // segment decision once both keys are in hand
  always_comb begin
    num        = t - key_a.stamp;
    den        = key_b.stamp - key_a.stamp;
    dec_held   = !single && (key_a.stamp > t);
    use_div    = 1'b0;
    dec_factor = '0;
    priority if (single || dec_held) dec_factor = '0;
    else if (key_b.stamp == key_a.stamp) dec_factor = ONE;
    else if (key_b.stamp < key_a.stamp) dec_factor = '0;
    else if (num >= den) dec_factor = ONE;
    else use_div = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && req_type == REQ_SAMPLE) begin
        state_next = (n_acc == NW'(1)) ? ST_RDA : ST_SCAN;
      end
      ST_SCAN: if (hit) state_next = ST_RDA;
      ST_RDA:  state_next = ST_GETA;
      ST_GETA: state_next = ST_DEC;
      ST_DEC:  state_next = use_div ? ST_DIV : ST_MUL;
      ST_DIV:  if (div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = (ax == 2'd2) ? ST_OUT : ST_MUL;
      ST_OUT:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    wr_en     = 1'b0;
    waddr     = AW'(key_slot);
    rd_en     = 1'b0;
    raddr     = '0;
    issue     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        wr_en    = in_acc && req_type == REQ_WRITE && (32'(key_slot) < MAX_KEYS);
      end
      ST_SCAN: begin
        issue = !hit && (cnt < n);
        rd_en = issue;
        raddr = AW'(cnt);
      end
      ST_RDA: begin
        rd_en = 1'b1;
        raddr = seg;
      end
      ST_DEC:  div_start = use_div;
      ST_OUT:  load_out  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  kpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // blend datapath: one multiplier shared by the three axes
  logic signed [KEY_W:0]   d;
  logic signed [PW-1:0]    prod;
  logic [KEY_W-1:0]        a_sel, b_sel;
  logic [KEY_W-1:0]        res_x, res_y, res_z;
  logic [KEY_W-1:0]        sum;

  always_comb begin
    unique case (ax)
      2'd0:    begin a_sel = key_a.x; b_sel = key_b.x; end
      2'd1:    begin a_sel = key_a.y; b_sel = key_b.y; end
      default: begin a_sel = key_a.z; b_sel = key_b.z; end
    endcase
    d   = $signed({b_sel[KEY_W-1], b_sel}) - $signed({a_sel[KEY_W-1], a_sel});
    // arithmetic shift gives the floor of the scaled product
    sum = a_sel + KEY_W'(prod >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rv        <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_SCAN) rv <= issue;
      else rv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        t      <= sample_time;
        n      <= n_acc;
        cnt    <= NW'(1);
        single <= (n_acc == NW'(1));
        seg    <= '0;
        ax     <= '0;
      end
      ST_SCAN: begin
        if (issue) begin
          ra  <= AW'(cnt);
          cnt <= cnt + 1'b1;
        end
        if (hit) begin
          key_b <= rdata;
          seg   <= ra - 1'b1;
        end
      end
      ST_GETA: begin
        key_a <= rdata;
        if (single) key_b <= rdata;
      end
      ST_DEC: begin
        factor <= dec_factor;
        held   <= dec_held;
      end
      ST_DIV:  if (div_done) factor <= FW'(div_quo);
      ST_MUL:  prod <= d * $signed({1'b0, factor});
      ST_ADD: begin
        unique case (ax)
          2'd0:    res_x <= sum;
          2'd1:    res_y <= sum;
          default: res_z <= sum;
        endcase
        ax <= ax + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_vx        <= res_x;
      out_vy        <= res_y;
      out_vz        <= res_z;
      segment_start <= 6'(32'(seg));
      blend_amount  <= factor;
      held_start    <= held;
    end
  end

endmodule
`default_nettype wire

@@ design/kpi_div.sv @@
// Restoring divider: (num << FRAC_BITS) / den for num < den, one bit per cycle
`default_nettype none
module kpi_div
  import kpi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [KEY_W-1:0]     num,
  input  wire logic [KEY_W-1:0]     den,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quo
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [KEY_W-1:0] rem;
  logic [KEY_W-1:0] dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [KEY_W:0]   shifted;
  logic             take;

  always_comb begin
    shifted = {rem, 1'b0};
    take    = shifted >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dv  <= den;
      quo <= '0;
    end else if (busy) begin
      // remainder stays below den, so it fits 32 bits
      rem <= take ? KEY_W'(shifted - {1'b0, dv}) : KEY_W'(shifted);
      quo <= {quo[FRAC_BITS-2:0], take};
    end
  end

endmodule
`default_nettype wire

@@ design/kpi_checker.sv @@
// Port-level checks of the keyframe interpolator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module kpi_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 req_type,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic signed [31:0]   out_vx,
  input wire logic [FRAC_BITS:0]   blend_amount,
  input wire logic                 held_start
);

  `KPI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_vx))
  `KPI_ASSERT(a_blend_max, out_valid, blend_amount <= ((FRAC_BITS + 1)'(1) << FRAC_BITS))
  `KPI_ASSERT(a_held_zero, out_valid && held_start, blend_amount == '0)
  `KPI_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && req_type, in_stall)

endmodule

bind keyframe_position_interpolator_top kpi_checker #(.FRAC_BITS(FRAC_BITS)) u_kpi_checker (.*);
`default_nettype wire

@@ bench/tb_keyframe_position_interpolator_top.sv @@
// Self-checking bench for the keyframe position interpolator
`default_nettype none
module tb_keyframe_position_interpolator_top;
  import kpi_pkg::*;

  localparam int NKEYS = 64;
  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [31:0] stamp;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] when;
  } req_t;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [5:0]  seg;
    logic [16:0] blend;
    logic        held;
  } pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_WRITE;
  logic [5:0] key_slot = '0;
  logic [31:0] key_stamp = '0;
  logic signed [31:0] key_vx = '0, key_vy = '0, key_vz = '0;
  logic [31:0] sample_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_vx, out_vy, out_vz;
  logic [5:0] segment_start;
  logic [FB:0] blend_amount;
  logic held_start;

  keyframe_position_interpolator_top u_dut (.*);

  // model state of the key table
  logic [31:0] mdl_stamp [NKEYS];
  logic [31:0] mdl_x [NKEYS];
  logic [31:0] mdl_y [NKEYS];
  logic [31:0] mdl_z [NKEYS];
  logic [6:0] mdl_count;

  req_t pending_reqs[$];
  pos_t expected_pos[$];
  int errors = 0;
  int cycles = 0;
  bit driver_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] lerp_axis(logic [31:0] a, logic [31:0] b, longint f);
    longint s, d, p, q;
    s = longint'($signed(a));
    d = longint'($signed(b)) - s;
    p = d * f;
    if (p >= 0) q = p >>> FB;
    else q = -((-p + ONE - 1) >>> FB);
    return 32'(s + q);
  endfunction

  // applies one accepted request to the model; sample requests queue a result
  task automatic predict_position(req_t r);
    int n, seg;
    logic [31:0] t1, t2;
    longint f;
    pos_t p;
    if (r.kind == REQ_WRITE) begin
      mdl_stamp[r.slot] = r.stamp;
      mdl_x[r.slot] = r.vx;
      mdl_y[r.slot] = r.vy;
      mdl_z[r.slot] = r.vz;
      return;
    end
    n = mdl_count;
    if (n == 0) n = 1;
    if (n > NKEYS) n = NKEYS;
    p = '0;
    if (n == 1) begin
      p.vx = mdl_x[0]; p.vy = mdl_y[0]; p.vz = mdl_z[0];
      expected_pos.insert(expected_pos.size(), p);
      return;
    end
    seg = n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (r.when < mdl_stamp[i+1]) begin
        seg = i;
        break;
      end
    end
    t1 = mdl_stamp[seg];
    t2 = mdl_stamp[seg+1];
    f = 0;
    if (t1 > r.when) begin
      p.held = 1'b1;
      p.vx = mdl_x[seg]; p.vy = mdl_y[seg]; p.vz = mdl_z[seg];
    end else begin
      if (t2 == t1) f = ONE;
      else if (t2 < t1) f = 0;
      else if (longint'(r.when - t1) >= longint'(t2 - t1)) f = ONE;
      else f = (longint'(r.when - t1) << FB) / longint'(t2 - t1);
      p.vx = lerp_axis(mdl_x[seg], mdl_x[seg+1], f);
      p.vy = lerp_axis(mdl_y[seg], mdl_y[seg+1], f);
      p.vz = lerp_axis(mdl_z[seg], mdl_z[seg+1], f);
    end
    p.seg = 6'(seg);
    p.blend = 17'(f);
    expected_pos.insert(expected_pos.size(), p);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_position(pending_reqs.pop_front());
        send_gap <= pick_gap();
      end
      if ((!in_valid || !in_stall)) begin
        if (in_valid && !in_stall && send_gap == 0 && pending_reqs.size() > 0
            && !driver_hold) begin
          // keep valid high, next transfer
          {req_type, key_slot, key_stamp, key_vx, key_vy, key_vz, sample_time}
            <= pending_reqs[0];
        end else if (in_valid && !in_stall) begin
          in_valid <= 1'b0;
        end else if (!in_valid && !driver_hold && pending_reqs.size() > 0) begin
          if (send_gap > 0) send_gap <= send_gap - 1;
          else begin
            in_valid <= 1'b1;
            {req_type, key_slot, key_stamp, key_vx, key_vy, key_vz, sample_time}
              <= pending_reqs[0];
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pos_t w;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          report_mismatch("unexpected transfer out_vx", out_vx, '0);
        end else begin
          w = expected_pos.pop_front();
          if (out_vx !== w.vx) report_mismatch("out_vx", out_vx, w.vx);
          if (out_vy !== w.vy) report_mismatch("out_vy", out_vy, w.vy);
          if (out_vz !== w.vz) report_mismatch("out_vz", out_vz, w.vz);
          if (segment_start !== w.seg) report_mismatch("segment_start", 32'(segment_start), 32'(w.seg));
          if (blend_amount !== w.blend) report_mismatch("blend_amount", 32'(blend_amount), 32'(w.blend));
          if (held_start !== w.held) report_mismatch("held_start", 32'(held_start), 32'(w.held));
        end
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout at cycle %0d", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic apb_write_count(logic [6:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_KEYS_IN_USE, 2'b00}; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_count = value;
  endtask

  task automatic push_key(int slot, logic [31:0] st, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z);
    req_t r;
    r = '0;
    r.kind = REQ_WRITE; r.slot = 6'(slot); r.stamp = st;
    r.vx = x; r.vy = y; r.vz = z;
    r.when = $urandom;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_sample(logic [31:0] t);
    req_t r;
    r = '0;
    r.kind = REQ_SAMPLE; r.when = t;
    r.slot = 6'($urandom); r.stamp = $urandom;
    r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_pos.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, sent, base;
    logic [31:0] st;
    bit hold_done;
    hold_done = 1'b0;
    for (int i = 0; i < NKEYS; i++) begin
      mdl_stamp[i] = '0; mdl_x[i] = '0; mdl_y[i] = '0; mdl_z[i] = '0;
    end
    mdl_count = 7'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: single key, extremes, hold, equal times, out of order
    push_key(0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_sample(32'hFFFF_FFFF);
    push_key(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    drain();
    apb_write_count(7'd2);
    push_sample(32'h0);
    push_sample(32'h8000_0000);
    push_sample(32'hFFFF_FFFE);
    push_sample(32'hFFFF_FFFF);
    push_key(0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    push_sample(32'h0000_8000);
    push_key(1, 32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0);
    push_sample(32'h0001_0000);
    push_key(1, 32'h0000_4000, 32'h0005_0000, 32'h0, 32'h0);
    push_sample(32'h0002_0000);
    push_key(2, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
    drain();
    apb_write_count(7'd3);
    push_sample(32'h0002_0000);
    push_sample(32'h0000_1000);
    drain();

    // fill every slot so any key count stays inside written entries
    for (int i = 0; i < NKEYS; i++)
      push_key(i, 32'(i) << 16, rand_val(), rand_val(), rand_val());
    drain();
    apb_write_count(7'd64);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0);
    drain();
    apb_write_count(7'd0);
    push_sample($urandom);
    drain();
    apb_write_count(7'd127);
    push_sample($urandom);
    drain();

    sent = 0;
    while (sent < 1300) begin
      n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8);
      apb_write_count(7'(n));
      // mostly ordered tables, some random rewrites
      base = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
      st = base;
      for (int i = 0; i < n && sent < 1300; i++) begin
        if ($urandom_range(0, 9) == 0) push_key(i, $urandom, rand_val(), rand_val(), rand_val());
        else push_key(i, st, rand_val(), rand_val(), rand_val());
        st = st + ($urandom_range(0, 7) == 0 ? 32'h0 : $urandom_range(1, 32'h0004_0000));
        sent++;
      end
      for (int k = 0; k < 12 && sent < 1300; k++) begin
        if ($urandom_range(0, 4) == 0) push_sample($urandom);
        else push_sample(32'(base) + $urandom_range(0, 32'h0010_0000) - 32'h1000);
        // rewrite a live key now and then with random content
        if ($urandom_range(0, 15) == 0)
          push_key($urandom_range(0, n - 1), $urandom, rand_val(), rand_val(), rand_val());
        sent++;
      end
      if (sent > 600 && !hold_done) begin
        // hold the sender until all results are back
        hold_done = 1'b1;
        driver_hold = 1'b1;
        while (expected_pos.size() > 0 || in_valid) @(posedge clk);
        driver_hold = 1'b0;
      end
      drain();
    end

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/kpi_pkg.sv
design/kpi_div.sv
design/keyframe_position_interpolator_top.sv
design/kpi_checker.sv
bench/tb_keyframe_position_interpolator_top.sv
